// ===== rtl/core/crfma_pkg.sv =====
`default_nettype none
package crfma_pkg;

  localparam int ID_W = 29;
  localparam int STATUS_W = 3;
  localparam int SLOT_W = 5;

  localparam logic [ID_W-1:0] STD_BITS = ID_W'(32'h7FF);
  localparam logic [ID_W-1:0] EXT_BITS = ID_W'(32'h1FFF_FFFF);

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] ST_COVERED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WIDENED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic ext;
    logic [ID_W-1:0] mask;
    logic [ID_W-1:0] id;
  } entry_t;

  function automatic logic [ID_W-1:0] trunc_for(input logic [ID_W-1:0] v, input logic ext);
    trunc_for = ext ? (v & EXT_BITS) : (v & STD_BITS);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/crfma_req_if.sv =====
`default_nettype none
interface crfma_req_if
  import crfma_pkg::*;
();
  logic valid;
  logic ready;
  logic func;
  logic ext;
  logic [ID_W-1:0] frame_id;
  logic [ID_W-1:0] id_mask;

  modport source(output valid, func, ext, frame_id, id_mask, input ready);
  modport sink(input valid, func, ext, frame_id, id_mask, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/crfma_rsp_if.sv =====
`default_nettype none
interface crfma_rsp_if
  import crfma_pkg::*;
();
  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0] slot;

  modport source(output valid, status, slot, input ready);
  modport sink(input valid, status, slot, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/can_rx_filter_merge_allocator_unit.sv =====
`default_nettype none
// CAN receive acceptance filter table. One request beat on req gives one result beat on rsp.
// A clear frees every slot but the reserved slot 0 and moves its result through the FINISH
// state into the output register. An add walks slots 1 to SLOTS-1 through the filter memory,
// with one READ step and one EVAL compare step per slot; it stops at slot k when slot k covers
// or is widened and walks every slot when the lowest free slot is allocated or the table is
// full. The free slot is tracked during the same walk. A new request is taken as soon as the
// previous result has moved into the output register.
module can_rx_filter_merge_allocator_unit
  import crfma_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input wire logic clk,
  input wire logic rst,
  crfma_req_if.sink req,
  crfma_rsp_if.source rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
  localparam logic [IW-1:0] FIRST = IW'(1);

  typedef enum logic [1:0] {IDLE, READ, EVAL, FINISH} state_t;

  state_t state;
  logic [SLOTS-1:0] slot_used;
  logic [IW-1:0] idx;
  logic [IW-1:0] free_idx;
  logic free_found;
  logic req_ext;
  logic [ID_W-1:0] req_id;
  logic [ID_W-1:0] req_mask;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0] res_slot;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot;

  entry_t mem [SLOTS];
  entry_t rd_data;
  logic mem_we;
  logic [IW-1:0] mem_wa;
  entry_t mem_wd;

  logic [ID_W-1:0] mnew, mold, diff;
  logic in_use, same_type, hit_cover, hit_widen, free_ok;
  logic [IW-1:0] free_pick;

  always_comb begin
    in_use = slot_used[idx];
    same_type = in_use && (rd_data.ext == req_ext);
    mnew = req_id & req_mask;
    mold = rd_data.id & rd_data.mask;
    diff = mnew ^ mold;
    hit_cover = same_type && (diff == '0) && ((req_id & rd_data.mask) == mold);
    hit_widen = same_type && (diff != '0) && ((diff & (diff - ID_W'(1))) == '0)
                && ((rd_data.mask & ~req_mask) == '0);
    free_ok = free_found || !in_use;
    free_pick = free_found ? free_idx : idx;

    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = rd_data;
    if (state == EVAL) begin
      if (hit_cover) begin
        mem_we = 1'b0;
      end else if (hit_widen) begin
        mem_we = 1'b1;
        mem_wd.mask = trunc_for(rd_data.mask & ~diff, req_ext);
      end else if (idx == LAST && free_ok) begin
        mem_we = 1'b1;
        mem_wa = free_pick;
        mem_wd.ext = req_ext;
        mem_wd.mask = trunc_for(req_mask, req_ext);
        mem_wd.id = trunc_for(req_id, req_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[idx];
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      slot_used <= SLOTS'(1);
      idx <= FIRST;
      free_found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req.valid) begin
            req_ext <= req.ext;
            req_id <= req.frame_id;
            req_mask <= req.id_mask;
            idx <= FIRST;
            free_found <= 1'b0;
            if (req.func == FUNC_CLEAR) begin
              slot_used <= SLOTS'(1);
              res_status <= ST_CLEARED;
              res_slot <= '0;
              state <= FINISH;
            end else begin
              state <= READ;
            end
          end
        end
        READ: begin
          state <= EVAL;
        end
        EVAL: begin
          if (!in_use && !free_found) begin
            free_found <= 1'b1;
            free_idx <= idx;
          end
          if (hit_cover) begin
            res_status <= ST_COVERED;
            res_slot <= SLOT_W'(idx);
            state <= FINISH;
          end else if (hit_widen) begin
            res_status <= ST_WIDENED;
            res_slot <= SLOT_W'(idx);
            state <= FINISH;
          end else if (idx == LAST) begin
            if (free_ok) begin
              slot_used[free_pick] <= 1'b1;
              res_status <= ST_ALLOCATED;
              res_slot <= SLOT_W'(free_pick);
            end else begin
              res_status <= ST_FULL;
              res_slot <= '0;
            end
            state <= FINISH;
          end else begin
            idx <= idx + FIRST;
            state <= READ;
          end
        end
        FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_status <= res_status;
            out_slot <= res_slot;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == IDLE);
  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.slot = out_slot;

  a_slot0_reserved: assert property (@(posedge clk) disable iff (rst) slot_used[0])
    else $error("reserved slot freed");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while busy");

  a_write_only_eval: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == EVAL))
    else $error("filter memory written outside compare step");

  a_full_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_FULL || out_status == ST_CLEARED)) |-> (out_slot == '0))
    else $error("nonzero slot on full or clear result");

endmodule
`default_nettype wire
